### design/bdrc_pkg.sv
package bdrc_pkg;

    localparam int SLOTS = 5;
    localparam int SLOT_W = 3;
    localparam int MAX_XFER = 128;
    localparam logic [SLOT_W-1:0] CD_SLOT = 3'd4;

    typedef enum logic [3:0] {
        MODE_READ    = 4'd0,
        MODE_WRITE   = 4'd1,
        MODE_VERIFY  = 4'd2,
        MODE_RESET   = 4'd3,
        MODE_RECAL   = 4'd4,
        MODE_PARAMS  = 4'd5,
        MODE_TYPE    = 4'd6,
        MODE_MOUNT   = 4'd7,
        MODE_UNMOUNT = 4'd8
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_MEDIA  = 3'd1,
        ST_BAD_CMD   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_WP        = 3'd4,
        ST_BAD_IMAGE = 3'd5
    } status_t;

    localparam logic [1:0] XFER_NONE  = 2'd0;
    localparam logic [1:0] XFER_READ  = 2'd1;
    localparam logic [1:0] XFER_WRITE = 2'd2;

    // slot table entry (geometry), held in memory
    typedef struct packed {
        logic [30:0] total;
        logic [10:0] cyls;
        logic [7:0]  heads;
        logic [5:0]  spt;
    } entry_t;

    function automatic logic [SLOT_W:0] slot_of(input logic [7:0] drive);
        logic [SLOT_W:0] s;
        begin
            s = 4'b1000;
            if (drive == 8'h80) s = 4'd0;
            else if (drive == 8'h81) s = 4'd1;
            else if (drive == 8'h00) s = 4'd2;
            else if (drive == 8'h01) s = 4'd3;
            else if (drive == 8'hE0) s = 4'd4;
            return s;
        end
    endfunction

endpackage

### design/bios_disk_request_checker.sv
// BIOS disk request checker. Keeps a five-slot drive table (disks 0x80/0x81,
// floppies 0x00/0x01, CD-ROM 0xE0) in a synchronous memory plus
// present/locked flag registers. Mount items check the image size and store
// the geometry; request items map CHS or LBA, clamp the count and check
// bounds and write protection, returning the byte span for a data mover.
// One item at a time. A request item passes through the table read, two
// chained CHS multiplies, the checks and the output, where m_tvalid rises.
// A disk or CD-ROM mount passes through size check and head pick, one
// reciprocal multiply for cylinders = blocks / (heads*63), table write and
// output. A floppy mount skips the multiply; an unmount or a failed mount
// goes from the size check straight to output. The output register holds
// the result until taken. s_tready returns the cycle after that, so a new
// item is taken only after the last result has been taken.
module bios_disk_request_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode[3:0], drive[11:4], lba[59:12], cylinder[69:60], head[77:70],
    // sector[83:78], count[99:84], buffer_bytes[120:100],
    // image_bytes[160:121], write_protect[161], zero fill to 168
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], reply_count[18:3], transfer[20:19], byte_offset[60:21],
    // byte_length[79:61], geo_cylinders[90:80], geo_heads[98:91],
    // geo_track_sectors[104:99], total_blocks[135:105], block_bytes[147:136],
    // params_type[150:148], zero fill to 152
    output logic [151:0] m_tdata
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_READ  = 8'b00000010,
        S_MUL1  = 8'b00000100,
        S_MUL2  = 8'b00001000,
        S_CHECK = 8'b00010000,
        S_DIV   = 8'b00100000,
        S_MWR   = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    // input latch
    logic [3:0]  mode_reg;
    logic [7:0]  drive_reg;
    logic [47:0] lba_reg;
    logic [9:0]  cyl_reg;
    logic [7:0]  head_reg;
    logic [5:0]  sec_reg;
    logic [15:0] count_reg;
    logic [20:0] buf_reg;
    logic [39:0] img_reg;
    logic        wp_reg;
    logic [bdrc_pkg::SLOT_W-1:0] slot_reg;
    logic        slot_ok_reg;

    logic [bdrc_pkg::SLOTS-1:0] present_reg, locked_reg;

    bdrc_pkg::entry_t mem [bdrc_pkg::SLOTS];
    bdrc_pkg::entry_t rd_reg;
    bdrc_pkg::entry_t wr_data;
    logic             mem_we;

    logic [17:0] t1_reg;       // cyl*heads
    logic [48:0] lin_reg;      // final lba (up to 2^48 + 2^32)
    logic [151:0] out_reg;
    logic         out_valid_reg;

    // cylinder divide by reciprocal multiply
    logic [7:0]  heads_sel_reg;
    logic        cyl_clamp_reg;
    logic        wide_reg;
    logic [23:0] qy_reg;
    logic [24:0] rcp_reg;
    logic [48:0] prod_reg;

    logic [bdrc_pkg::SLOT_W:0] slot_in;
    assign slot_in = bdrc_pkg::slot_of(s_tdata[11:4]);

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    logic is_cd, is_fl;
    assign is_cd = slot_reg == bdrc_pkg::CD_SLOT;
    assign is_fl = (slot_reg == 3'd2) || (slot_reg == 3'd3);

    // mount size check and blocks
    logic        size_ok;
    logic [30:0] blocks;
    logic [42:0] mb_bytes;
    logic [22:0] mb;
    logic [7:0]  heads_sz;
    logic [2:0]  mnt_status;
    always_comb
    begin
        if (is_cd) size_ok = img_reg >= 40'd34816;
        else if (is_fl)
            size_ok = img_reg == 40'd163840 || img_reg == 40'd184320 ||
                      img_reg == 40'd327680 || img_reg == 40'd368640 ||
                      img_reg == 40'd737280 || img_reg == 40'd1228800 ||
                      img_reg == 40'd1474560 || img_reg == 40'd2949120;
        else size_ok = img_reg >= 40'd512;
        blocks = is_cd ? {2'b0, img_reg[39:11]} : img_reg[39:9];
        mb_bytes = is_cd ? {1'b0, blocks, 11'd0} : {3'b0, blocks, 9'd0};
        mb = mb_bytes[42:20];
        if (mb <= 23'd504) heads_sz = 8'd16;
        else if (mb <= 23'd1008) heads_sz = 8'd32;
        else if (mb <= 23'd2016) heads_sz = 8'd64;
        else if (mb <= 23'd4032) heads_sz = 8'd128;
        else heads_sz = 8'd255;
        mnt_status = bdrc_pkg::ST_OK;
        if (mode_reg == bdrc_pkg::MODE_MOUNT)
            mnt_status = !slot_ok_reg ? bdrc_pkg::ST_BAD_CMD :
                         (size_ok ? bdrc_pkg::ST_OK : bdrc_pkg::ST_BAD_IMAGE);
        else if (mode_reg == bdrc_pkg::MODE_UNMOUNT && !slot_ok_reg)
            mnt_status = bdrc_pkg::ST_BAD_CMD;
    end

    // cylinders = blocks / (heads*63), capped at 1024.
    // Power-of-two heads: shift, then x/63 as (x * 66577) >> 22 (x < 64512).
    // 255 heads: (x * 17110359) >> 38, exact for x < 2^24.
    logic [26:0] hq;
    logic [23:0] qy;
    logic [24:0] rcp;
    logic        cyl_clamp;
    always_comb
    begin
        hq = 27'(blocks >> 4);
        if (heads_sz == 8'd32) hq = 27'(blocks >> 5);
        else if (heads_sz == 8'd64) hq = 27'(blocks >> 6);
        else if (heads_sz == 8'd128) hq = 27'(blocks >> 7);
        if (heads_sz == 8'd255)
        begin
            cyl_clamp = blocks >= 31'd16450560;
            qy        = blocks[23:0];
            rcp       = 25'd17110359;
        end
        else
        begin
            cyl_clamp = hq >= 27'd64512;
            qy        = {8'd0, hq[15:0]};
            rcp       = 25'd66577;
        end
    end

    // request checks
    logic [11:0] bsize;
    logic [15:0] cnt_c;
    logic [19:0] len;
    logic [49:0] end_blk;
    logic [151:0] res;
    logic [1:0]  xfer;
    logic [39:0] offs;
    always_comb
    begin
        bsize = is_cd ? 12'd2048 : 12'd512;
        cnt_c = (count_reg > 16'(bdrc_pkg::MAX_XFER)) ? 16'(bdrc_pkg::MAX_XFER)
                                                      : count_reg;
        len = is_cd ? {cnt_c[8:0], 11'd0} : {2'b0, cnt_c[8:0], 9'd0};
        offs = is_cd ? {lin_reg[28:0], 11'd0} : {lin_reg[30:0], 9'd0};
        xfer = (mode_reg == bdrc_pkg::MODE_READ) ? bdrc_pkg::XFER_READ
                                                 : bdrc_pkg::XFER_WRITE;
        end_blk = '0;
        res = '0;
        if (!slot_ok_reg || !present_reg[slot_reg])
            res[2:0] = bdrc_pkg::ST_NO_MEDIA;
        else
        begin
            unique case (mode_reg)
                bdrc_pkg::MODE_READ, bdrc_pkg::MODE_WRITE:
                begin
                    end_blk = {1'b0, lin_reg} + {34'd0, cnt_c};
                    if (mode_reg == bdrc_pkg::MODE_READ && buf_reg < {1'b0, len})
                        res[2:0] = bdrc_pkg::ST_BAD_CMD;
                    else if (mode_reg == bdrc_pkg::MODE_WRITE && locked_reg[slot_reg])
                        res[2:0] = bdrc_pkg::ST_WP;
                    else if (end_blk > {19'd0, rd_reg.total})
                        res[2:0] = bdrc_pkg::ST_NOT_FOUND;
                    else
                    begin
                        res[18:3]   = cnt_c;
                        res[20:19]  = xfer;
                        res[60:21]  = offs;
                        res[79:61]  = len[18:0];
                    end
                end
                bdrc_pkg::MODE_VERIFY:
                begin
                    end_blk = {1'b0, lin_reg} + {34'd0, count_reg};
                    if (end_blk <= {19'd0, rd_reg.total}) res[18:3] = count_reg;
                    else res[2:0] = bdrc_pkg::ST_NOT_FOUND;
                end
                bdrc_pkg::MODE_RESET, bdrc_pkg::MODE_RECAL: end_blk = '0;
                bdrc_pkg::MODE_PARAMS:
                begin
                    end_blk = '0;
                    res[18:3]    = 16'd28;
                    res[90:80]   = rd_reg.cyls;
                    res[98:91]   = rd_reg.heads;
                    res[104:99]  = rd_reg.spt;
                    res[135:105] = rd_reg.total;
                    res[147:136] = bsize;
                    res[150:148] = drive_reg[7] ? 3'd3 : 3'd4;
                end
                bdrc_pkg::MODE_TYPE:
                begin
                    end_blk = '0;
                    res[18:3] = (drive_reg >= 8'hE0) ? 16'd5 :
                                (drive_reg[7] ? 16'd3 : 16'd4);
                end
                default:
                begin
                    end_blk = '0;
                    res[2:0] = bdrc_pkg::ST_BAD_CMD;
                end
            endcase
        end
    end

    // memory
    always_ff @(posedge clk)
    begin
        if (mem_we) mem[slot_reg] <= wr_data;
        rd_reg <= mem[slot_reg];
    end

    always_comb
    begin
        wr_data.total = blocks;
        wr_data.heads = heads_sel_reg;
        wr_data.spt   = 6'd63;
        wr_data.cyls  = cyl_clamp_reg ? 11'd1024 :
                        (wide_reg ? prod_reg[48:38] : prod_reg[32:22]);
        if (is_fl)
        begin
            wr_data.cyls = 11'd80; wr_data.heads = 8'd2; wr_data.spt = 6'd18;
            if (img_reg == 40'd1228800) wr_data.spt = 6'd15;
            else if (img_reg == 40'd737280) wr_data.spt = 6'd9;
            else if (img_reg == 40'd368640)
            begin
                wr_data.cyls = 11'd40; wr_data.spt = 6'd9;
            end
            else if (img_reg == 40'd163840)
            begin
                wr_data.cyls = 11'd40; wr_data.heads = 8'd1; wr_data.spt = 6'd8;
            end
        end
        mem_we = state_reg == S_MWR;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_tvalid && s_tready) state_next = S_READ;
            S_READ:
            begin
                if (mode_reg == bdrc_pkg::MODE_MOUNT && slot_ok_reg && size_ok && !is_fl)
                    state_next = S_DIV;
                else if (mode_reg == bdrc_pkg::MODE_MOUNT && slot_ok_reg && size_ok)
                    state_next = S_MWR;
                else if (mode_reg == bdrc_pkg::MODE_MOUNT ||
                         mode_reg == bdrc_pkg::MODE_UNMOUNT)
                    state_next = S_OUT;
                else
                    state_next = S_MUL1;
            end
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_CHECK;
            S_CHECK: state_next = S_OUT;
            S_DIV:   state_next = S_MWR;
            S_MWR:   state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            present_reg   <= '0;
            locked_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            if (state_reg == S_READ && slot_ok_reg &&
                (mode_reg == bdrc_pkg::MODE_MOUNT || mode_reg == bdrc_pkg::MODE_UNMOUNT))
            begin
                present_reg[slot_reg] <= 1'b0;
                locked_reg[slot_reg]  <= 1'b0;
            end
            if (state_reg == S_MWR)
            begin
                present_reg[slot_reg] <= 1'b1;
                locked_reg[slot_reg]  <= is_cd || wp_reg;
            end
            if (state_reg == S_CHECK || state_reg == S_MWR ||
                (state_reg == S_READ && state_next == S_OUT))
                out_valid_reg <= 1'b0;
            if (state_reg == S_OUT) out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            mode_reg    <= s_tdata[3:0];
            drive_reg   <= s_tdata[11:4];
            lba_reg     <= s_tdata[59:12];
            cyl_reg     <= s_tdata[69:60];
            head_reg    <= s_tdata[77:70];
            sec_reg     <= s_tdata[83:78];
            count_reg   <= s_tdata[99:84];
            buf_reg     <= s_tdata[120:100];
            img_reg     <= s_tdata[160:121];
            wp_reg      <= s_tdata[161];
            slot_reg    <= slot_in[bdrc_pkg::SLOT_W] ? 3'd0 : slot_in[2:0];
            slot_ok_reg <= !slot_in[bdrc_pkg::SLOT_W];
        end
        if (state_reg == S_READ)
        begin
            // prepare mount divide and result
            out_reg       <= {149'd0, mnt_status};
            heads_sel_reg <= heads_sz;
            cyl_clamp_reg <= cyl_clamp;
            wide_reg      <= heads_sz == 8'd255;
            qy_reg        <= qy;
            rcp_reg       <= rcp;
        end
        if (state_reg == S_DIV)
            prod_reg <= {25'd0, qy_reg} * {24'd0, rcp_reg};
        if (state_reg == S_MUL1)
            t1_reg <= 18'(cyl_reg) * 18'(rd_reg.heads);
        if (state_reg == S_MUL2)
        begin
            if (lba_reg == 48'd0)
                lin_reg <= 49'((({1'b0, t1_reg} + {11'd0, head_reg}) * rd_reg.spt)
                          + {17'd0, 32'({26'd0, sec_reg} - 32'd1)});
            else
                lin_reg <= {1'b0, lba_reg};
        end
        if (state_reg == S_CHECK)
            out_reg <= res;
    end

    a_one_state: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input taken while result pending");
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == S_OUT)
        else $error("result without finish");

endmodule

### tb/bios_disk_request_checker_tb.sv
module bios_disk_request_checker_tb;

    // input item as packed on s_tdata, last field in the low bits
    typedef struct packed {
        logic [5:0]  pad;
        logic        write_protect;
        logic [39:0] image_bytes;
        logic [20:0] buffer_bytes;
        logic [15:0] count;
        logic [5:0]  sector;
        logic [7:0]  head;
        logic [9:0]  cylinder;
        logic [47:0] lba;
        logic [7:0]  drive;
        logic [3:0]  mode;
    } req_item_t;

    // result item as packed on m_tdata
    typedef struct packed {
        logic        pad;
        logic [2:0]  params_type;
        logic [11:0] block_bytes;
        logic [30:0] total_blocks;
        logic [5:0]  geo_track_sectors;
        logic [7:0]  geo_heads;
        logic [10:0] geo_cylinders;
        logic [18:0] byte_length;
        logic [39:0] byte_offset;
        logic [1:0]  transfer;
        logic [15:0] reply_count;
        logic [2:0]  status;
    } reply_item_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1850;
    localparam logic [39:0] CD_MIN_BYTES = 40'd34816;  // 17 CD sectors

    // Drive table model plus the queue of replies it predicts.
    class disk_table_scoreboard;
        bit          present [bdrc_pkg::SLOTS];
        bit          locked  [bdrc_pkg::SLOTS];
        logic [30:0] blocks  [bdrc_pkg::SLOTS];
        logic [10:0] cyls    [bdrc_pkg::SLOTS];
        logic [7:0]  heads   [bdrc_pkg::SLOTS];
        logic [5:0]  spt     [bdrc_pkg::SLOTS];
        reply_item_t pending [$];
        int          errors;

        function new();
            for (int i = 0; i < bdrc_pkg::SLOTS; i++)
            begin
                present[i] = 0;
                locked[i] = 0;
            end
            errors = 0;
        endfunction

        function int slot_for(logic [7:0] drive);
            case (drive)
                8'h80: return 0;
                8'h81: return 1;
                8'h00: return 2;
                8'h01: return 3;
                8'hE0: return 4;
                default: return -1;
            endcase
        endfunction

        function bit mount_slot(int s, logic [39:0] img, bit wp);
            bit ok;
            logic [63:0] bs, tot, mb, hd, cy;
            ok = 0;
            present[s] = 0;
            locked[s] = 0;
            bs = (s == bdrc_pkg::CD_SLOT) ? 64'd2048 : 64'd512;
            if (s == bdrc_pkg::CD_SLOT)
                ok = img >= CD_MIN_BYTES;
            else if (s == 2 || s == 3)
                ok = img inside {40'd163840, 40'd184320, 40'd327680, 40'd368640,
                                 40'd737280, 40'd1228800, 40'd1474560, 40'd2949120};
            else
                ok = img >= 40'd512;
            if (!ok)
                return 0;
            tot = (64'(img) / bs) & 64'h7FFF_FFFF;
            blocks[s] = tot[30:0];
            if (s == 2 || s == 3)
            begin
                cyls[s] = 11'd80; heads[s] = 8'd2; spt[s] = 6'd18;
                if (img == 40'd1228800) spt[s] = 6'd15;
                else if (img == 40'd737280) spt[s] = 6'd9;
                else if (img == 40'd368640)
                begin
                    cyls[s] = 11'd40; spt[s] = 6'd9;
                end
                else if (img == 40'd163840)
                begin
                    cyls[s] = 11'd40; heads[s] = 8'd1; spt[s] = 6'd8;
                end
            end
            else
            begin
                // heads chosen by size in MiB, 63 sectors, cylinders capped
                mb = (tot * bs) >> 20;
                if (mb <= 504) hd = 16;
                else if (mb <= 1008) hd = 32;
                else if (mb <= 2016) hd = 64;
                else if (mb <= 4032) hd = 128;
                else hd = 255;
                cy = tot / (hd * 63);
                if (cy > 1024) cy = 1024;
                cyls[s] = cy[10:0];
                heads[s] = hd[7:0];
                spt[s] = 6'd63;
            end
            locked[s] = (s == bdrc_pkg::CD_SLOT) || wp;
            present[s] = 1;
            return 1;
        endfunction

        // accepted input item: update the table, queue the expected reply
        function void note_request(req_item_t it);
            reply_item_t r;
            int s;
            logic [63:0] bs, addr, cnt, len, tot;
            logic [31:0] sec_m1;
            r = '0;
            s = slot_for(it.drive);
            if (it.mode == bdrc_pkg::MODE_MOUNT || it.mode == bdrc_pkg::MODE_UNMOUNT)
            begin
                if (s < 0)
                    r.status = bdrc_pkg::ST_BAD_CMD;
                else if (it.mode == bdrc_pkg::MODE_MOUNT)
                    r.status = mount_slot(s, it.image_bytes, it.write_protect)
                               ? bdrc_pkg::ST_OK : bdrc_pkg::ST_BAD_IMAGE;
                else
                begin
                    present[s] = 0;
                    locked[s] = 0;
                end
            end
            else if (s < 0 || !present[s])
                r.status = bdrc_pkg::ST_NO_MEDIA;
            else
            begin
                bs = (s == bdrc_pkg::CD_SLOT) ? 64'd2048 : 64'd512;
                tot = 64'(blocks[s]);
                addr = 64'(it.lba);
                if (addr == 0)
                begin
                    // CHS: sector zero wraps to 0xFFFFFFFF
                    sec_m1 = 32'(it.sector) - 32'd1;
                    addr = (64'(it.cylinder) * 64'(heads[s]) + 64'(it.head))
                           * 64'(spt[s]) + 64'(sec_m1);
                end
                cnt = 64'(it.count);
                case (it.mode)
                    bdrc_pkg::MODE_READ, bdrc_pkg::MODE_WRITE:
                    begin
                        if (cnt > 64'(bdrc_pkg::MAX_XFER)) cnt = 64'(bdrc_pkg::MAX_XFER);
                        len = cnt * bs;
                        if (it.mode == bdrc_pkg::MODE_READ && 64'(it.buffer_bytes) < len)
                            r.status = bdrc_pkg::ST_BAD_CMD;
                        else if (it.mode == bdrc_pkg::MODE_WRITE && locked[s])
                            r.status = bdrc_pkg::ST_WP;
                        else if (addr + cnt > tot)
                            r.status = bdrc_pkg::ST_NOT_FOUND;
                        else
                        begin
                            r.reply_count = cnt[15:0];
                            r.transfer = (it.mode == bdrc_pkg::MODE_READ) ?
                                         bdrc_pkg::XFER_READ : bdrc_pkg::XFER_WRITE;
                            r.byte_offset = 40'(addr * bs);
                            r.byte_length = len[18:0];
                        end
                    end
                    bdrc_pkg::MODE_VERIFY:
                        if (addr + cnt <= tot) r.reply_count = cnt[15:0];
                        else r.status = bdrc_pkg::ST_NOT_FOUND;
                    bdrc_pkg::MODE_RESET, bdrc_pkg::MODE_RECAL: ;
                    bdrc_pkg::MODE_PARAMS:
                    begin
                        r.reply_count = 16'd28;
                        r.geo_cylinders = cyls[s];
                        r.geo_heads = heads[s];
                        r.geo_track_sectors = spt[s];
                        r.total_blocks = blocks[s];
                        r.block_bytes = bs[11:0];
                        r.params_type = (it.drive >= 8'h80) ? 3'd3 : 3'd4;
                    end
                    bdrc_pkg::MODE_TYPE:
                        r.reply_count = (it.drive >= 8'hE0) ? 16'd5 :
                                        (it.drive >= 8'h80) ? 16'd3 : 16'd4;
                    default:
                        r.status = bdrc_pkg::ST_BAD_CMD;
                endcase
            end
            pending.push_back(r);
        endfunction

        function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_reply(reply_item_t a);
            reply_item_t e;
            if (pending.size() == 0)
            begin
                $error("reply item with nothing pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("status", e.status, a.status);
            cmp("reply_count", e.reply_count, a.reply_count);
            cmp("transfer", e.transfer, a.transfer);
            cmp("byte_offset", e.byte_offset, a.byte_offset);
            cmp("byte_length", e.byte_length, a.byte_length);
            cmp("geo_cylinders", e.geo_cylinders, a.geo_cylinders);
            cmp("geo_heads", e.geo_heads, a.geo_heads);
            cmp("geo_track_sectors", e.geo_track_sectors, a.geo_track_sectors);
            cmp("total_blocks", e.total_blocks, a.total_blocks);
            cmp("block_bytes", e.block_bytes, a.block_bytes);
            cmp("params_type", e.params_type, a.params_type);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [167:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;

    disk_table_scoreboard sb;
    int idle_cycles;

    bios_disk_request_checker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        rst_n = 0;
    end

    always #4 clk = ~clk;

    // mostly short gaps, now and then a long one
    function int gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 2);
        return $urandom_range(3, 40);
    endfunction

    // monitors: both sides sampled at the edge, before nonblocking updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(req_item_t'(s_tdata));
            if (m_tvalid && m_tready)
                sb.check_reply(reply_item_t'(m_tdata));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog: too long without any item moving
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[bios_disk_request_checker] ERROR");
            $finish;
        end
    end

    // receiver: stretches of steady ready and stretches of random stalls, in random order
    initial
    begin
        int run_len;
        bit steady;
        @(posedge rst_n);
        forever
        begin
            steady = $urandom_range(0, 3) == 0;
            run_len = $urandom_range(20, 200);
            repeat (run_len)
            begin
                @(posedge clk);
                if (!steady && $urandom_range(0, 30) == 0)
                begin
                    m_tready <= 0;
                    repeat ($urandom_range(5, 40)) @(posedge clk);
                end
                else if (steady || $urandom_range(0, 9) < 7)
                    m_tready <= 1;
                else
                    m_tready <= 0;
            end
        end
    end

    // caller is at a rising edge; returns at the accepting edge plus gap
    task automatic send_item(req_item_t it, bit no_gap);
        int g;
        s_tdata <= it;
        s_tvalid <= 1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        g = no_gap ? 0 : gap_len();
        if (g > 0)
        begin
            s_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
    endtask

    function req_item_t mk(logic [3:0] mode, logic [7:0] drive, logic [47:0] lba,
                           logic [9:0] cyl, logic [7:0] hd, logic [5:0] sec,
                           logic [15:0] cnt, logic [20:0] buf_b,
                           logic [39:0] img, bit wp);
        req_item_t it;
        it = '0;
        it.mode = mode; it.drive = drive; it.lba = lba;
        it.cylinder = cyl; it.head = hd; it.sector = sec;
        it.count = cnt; it.buffer_bytes = buf_b;
        it.image_bytes = img; it.write_protect = wp;
        return it;
    endfunction

    function logic [7:0] pick_drive();
        case ($urandom_range(0, 11))
            0, 1, 2: return 8'h80;
            3, 4:    return 8'h81;
            5, 6:    return 8'h00;
            7, 8:    return 8'h01;
            9, 10:   return 8'hE0;
            default: return 8'($urandom);
        endcase
    endfunction

    function logic [39:0] pick_image(logic [7:0] drive);
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        if ((drive == 8'h00 || drive == 8'h01) && $urandom_range(0, 9) < 8)
        begin
            case ($urandom_range(0, 7))
                0: return 40'd163840;
                1: return 40'd184320;
                2: return 40'd327680;
                3: return 40'd368640;
                4: return 40'd737280;
                5: return 40'd1228800;
                6: return 40'd1474560;
                default: return 40'd2949120;
            endcase
        end
        case ($urandom_range(0, 9))
            0: return 40'(wide);                                  // any size
            1: return 40'($urandom_range(0, 40000));              // near minimums
            default: return 40'(wide >> $urandom_range(28, 56));  // mid range
        endcase
    endfunction

    function req_item_t random_item();
        req_item_t it;
        int k;
        it = '0;
        it.drive = pick_drive();
        k = $urandom_range(0, 99);
        if (k < 12) it.mode = bdrc_pkg::MODE_MOUNT;
        else if (k < 16) it.mode = bdrc_pkg::MODE_UNMOUNT;
        else if (k < 19) it.mode = 4'($urandom_range(9, 15));
        else it.mode = 4'($urandom_range(0, 6));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: it.lba = '0;
            4, 5, 6:    it.lba = 48'($urandom_range(1, 2880));
            7, 8:       it.lba = 48'($urandom_range(1, 4_000_000));
            default:    it.lba = 48'({$urandom, $urandom});
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            it.cylinder = 10'($urandom);
            it.head = 8'($urandom);
        end
        else
        begin
            it.cylinder = 10'($urandom_range(0, 80));
            it.head = 8'($urandom_range(0, 3));
        end
        it.sector = 6'($urandom);
        it.count = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 140));
        case ($urandom_range(0, 7))
            0:       it.buffer_bytes = 21'($urandom_range(0, 1048576));
            1:       it.buffer_bytes = 21'($urandom_range(0, 4096));
            default: it.buffer_bytes = 21'd1048576;
        endcase
        it.image_bytes = pick_image(it.drive);
        it.write_protect = $urandom_range(0, 3) == 0;
        return it;
    endfunction

    initial
    begin
        sb = new();
        idle_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: mounts at size edges, then each mode and corner case
        send_item(mk(bdrc_pkg::MODE_MOUNT, 8'h80, 0, 0, 0, 0, 0, 0, 40'd511, 0), 0);
        send_item(mk(bdrc_pkg::MODE_MOUNT, 8'h80, 0, 0, 0, 0, 0, 0, 40'd512, 0), 0);
        send_item(mk(bdrc_pkg::MODE_PARAMS, 8'h80, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_item(mk(bdrc_pkg::MODE_MOUNT, 8'h80, 0, 0, 0, 0, 0, 0, 40'hFF_FFFF_FFFF, 0), 0);
        send_item(mk(bdrc_pkg::MODE_PARAMS, 8'h80, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_item(mk(bdrc_pkg::MODE_MOUNT, 8'h81, 0, 0, 0, 0, 0, 0, 40'd629145600, 1), 0);
        send_item(mk(bdrc_pkg::MODE_MOUNT, 8'h00, 0, 0, 0, 0, 0, 0, 40'd163840, 0), 0);
        send_item(mk(bdrc_pkg::MODE_MOUNT, 8'h01, 0, 0, 0, 0, 0, 0, 40'd1474560, 1), 0);
        send_item(mk(bdrc_pkg::MODE_MOUNT, 8'h01, 0, 0, 0, 0, 0, 0, 40'd1474561, 0), 0);
        send_item(mk(bdrc_pkg::MODE_MOUNT, 8'h01, 0, 0, 0, 0, 0, 0, 40'd2949120, 1), 0);
        send_item(mk(bdrc_pkg::MODE_MOUNT, 8'hE0, 0, 0, 0, 0, 0, 0, CD_MIN_BYTES - 1, 0), 0);
        send_item(mk(bdrc_pkg::MODE_MOUNT, 8'hE0, 0, 0, 0, 0, 0, 0, CD_MIN_BYTES, 0), 0);
        send_item(mk(bdrc_pkg::MODE_MOUNT, 8'h55, 0, 0, 0, 0, 0, 0, 40'd512, 0), 0);
        send_item(mk(bdrc_pkg::MODE_READ, 8'h42, 0, 0, 0, 1, 1, 21'd1048576, 0, 0), 0);
        // CHS sector zero wraps and misses
        send_item(mk(bdrc_pkg::MODE_READ, 8'h00, 0, 0, 0, 0, 1, 21'd1048576, 0, 0), 0);
        send_item(mk(bdrc_pkg::MODE_READ, 8'h00, 0, 39, 0, 8, 1, 21'd1048576, 0, 0), 0);
        // count clamps to 128, then buffer too small
        send_item(mk(bdrc_pkg::MODE_READ, 8'h80, 48'd1, 0, 0, 0, 16'hFFFF, 21'd1048576,
                     0, 0), 0);
        send_item(mk(bdrc_pkg::MODE_READ, 8'h80, 48'd1, 0, 0, 0, 16'd8, 21'd4095, 0, 0), 0);
        send_item(mk(bdrc_pkg::MODE_WRITE, 8'h01, 48'd5, 0, 0, 0, 16'd1, 0, 0, 0), 0);
        send_item(mk(bdrc_pkg::MODE_WRITE, 8'h80, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 1, 0, 0, 0), 0);
        send_item(mk(bdrc_pkg::MODE_VERIFY, 8'h80, 48'd1, 0, 0, 0, 16'hFFFF, 0, 0, 0), 0);
        send_item(mk(bdrc_pkg::MODE_RESET, 8'h80, 0, 0, 0, 1, 0, 0, 0, 0), 0);
        send_item(mk(bdrc_pkg::MODE_RECAL, 8'h81, 0, 0, 0, 1, 0, 0, 0, 0), 0);
        send_item(mk(bdrc_pkg::MODE_TYPE, 8'hE0, 0, 0, 0, 1, 0, 0, 0, 0), 0);
        send_item(mk(4'd15, 8'h80, 0, 0, 0, 1, 0, 0, 0, 0), 0);
        send_item(mk(bdrc_pkg::MODE_UNMOUNT, 8'h81, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_item(mk(bdrc_pkg::MODE_UNMOUNT, 8'h81, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_item(mk(bdrc_pkg::MODE_PARAMS, 8'h81, 0, 0, 0, 0, 0, 0, 0, 0), 0);

        // random part, with back-to-back bursts now and then
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_item(random_item(), (n / 64) % 4 == 1);
        s_tvalid <= 0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0)
            $display("[bios_disk_request_checker] OK");
        else
            $display("[bios_disk_request_checker] ERROR");
        $finish;
    end

endmodule

### sim.f
design/bdrc_pkg.sv
design/bios_disk_request_checker.sv
tb/bios_disk_request_checker_tb.sv
